// File: sv/b2bcd_pkg.sv
`timescale 1ns / 1ps

package b2bcd_pkg;

  // Field widths
  localparam int unsigned CmdW      = 2;
  localparam int unsigned ValW      = 32;
  localparam int unsigned OutW      = 32;
  localparam int unsigned Dig4InW   = 16;

  // Full conversion of a 32-bit value needs ten decimal digits
  localparam int unsigned BcdDigits = 10;
  localparam int unsigned BcdW      = 4 * BcdDigits;

  // Shift-and-add steps per pipeline stage; one step per input bit overall
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumStages     = ValW / StepsPerStage;

  // Digit count selection
  typedef enum logic [CmdW-1:0] {
    CmdDig4    = 2'd0,
    CmdDig6    = 2'd1,
    CmdDig8    = 2'd2,
    CmdDig8Alt = 2'd3
  } cmd_e;

  // Word carried down the pipeline
  typedef struct packed {
    cmd_e            cmd;
    logic [BcdW-1:0] bcd;
    logic [ValW-1:0] bin;
  } stage_data_t;

  // One double-dabble step: correct digits >= 5, then shift left by one
  function automatic stage_data_t dabble_step(stage_data_t d);
    stage_data_t     r;
    logic [BcdW-1:0] adj;
    r   = d;
    adj = d.bcd;
    for (int i = 0; i < BcdDigits; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    {r.bcd, r.bin} = {adj, d.bin} << 1;
    return r;
  endfunction

  // Keeps the selected number of low digits
  function automatic logic [OutW-1:0] digit_mask(cmd_e cmd);
    logic [OutW-1:0] m;
    unique case (cmd)
      CmdDig4:    m = 32'h0000_FFFF;
      CmdDig6:    m = 32'h00FF_FFFF;
      CmdDig8:    m = 32'hFFFF_FFFF;
      CmdDig8Alt: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // True when every nibble holds a decimal digit
  function automatic logic bcd_digits_ok(logic [OutW-1:0] w);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < OutW / 4; i++) begin
      if (w[4*i +: 4] > 4'd9) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

endpackage

// File: sv/b2bcd_req_if.sv
`timescale 1ns / 1ps

interface b2bcd_req_if;
  logic                         valid;
  logic                         ready;
  logic [b2bcd_pkg::CmdW-1:0]   command;
  logic [b2bcd_pkg::ValW-1:0]   value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

// File: sv/b2bcd_res_if.sv
`timescale 1ns / 1ps

interface b2bcd_res_if;
  logic                         valid;
  logic                         ready;
  logic [b2bcd_pkg::OutW-1:0]   bcd;

  modport source (output valid, output bcd, input ready);
  modport sink   (input valid, input bcd, output ready);
endinterface

// File: sv/b2bcd_stage.sv
`timescale 1ns / 1ps

module b2bcd_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  b2bcd_pkg::stage_data_t data_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output b2bcd_pkg::stage_data_t data_o
);

  logic                   valid_q;
  b2bcd_pkg::stage_data_t data_q;
  b2bcd_pkg::stage_data_t data_d;

  // Slot frees when empty or when the next stage takes the request
  assign ready_o = !valid_q || ready_i;

  // Shift-and-add steps of this stage
  always_comb begin
    data_d = data_i;
    for (int s = 0; s < b2bcd_pkg::StepsPerStage; s++) begin
      data_d = b2bcd_pkg::dabble_step(data_d);
    end
  end

  // Valid bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: sv/binary_to_bcd_converter_top.sv
`timescale 1ns / 1ps
// An accepted request is registered in each stage in turn before its result is valid.
// Throughput: one request per cycle unless the result side stalls; eight stages
//   of four shift-and-add steps each (one step per input bit) set the depth.
// Backpressure holds a stage only while it is occupied; empty slots still fill.
// Reset (asynchronous, active low) clears the stage valid bits only.

module binary_to_bcd_converter_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  b2bcd_req_if.sink          req_i,
  b2bcd_res_if.source        res_o
);

  localparam int unsigned NS = b2bcd_pkg::NumStages;

  logic [NS:0]            pipe_valid;
  logic [NS:0]            pipe_ready;
  b2bcd_pkg::stage_data_t pipe_data [NS+1];
  b2bcd_pkg::cmd_e        in_cmd;
  b2bcd_pkg::cmd_e        out_cmd;

  // Pipeline entry: 4-digit mode uses the low 16 bits only
  assign in_cmd = b2bcd_pkg::cmd_e'(req_i.command);

  always_comb begin
    pipe_data[0].cmd = in_cmd;
    pipe_data[0].bcd = '0;
    if (in_cmd == b2bcd_pkg::CmdDig4) begin
      pipe_data[0].bin = {{(b2bcd_pkg::ValW - b2bcd_pkg::Dig4InW){1'b0}},
                          req_i.value[b2bcd_pkg::Dig4InW-1:0]};
    end else begin
      pipe_data[0].bin = req_i.value;
    end
  end

  assign pipe_valid[0] = req_i.valid;
  assign req_i.ready   = pipe_ready[0];

  // Stage chain
  for (genvar g = 0; g < NS; g++) begin : g_stage
    b2bcd_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (pipe_valid[g]),
      .ready_o (pipe_ready[g]),
      .data_i  (pipe_data[g]),
      .valid_o (pipe_valid[g+1]),
      .ready_i (pipe_ready[g+1]),
      .data_o  (pipe_data[g+1])
    );
  end

  // Result: keep the selected low digits of the full conversion
  assign out_cmd        = pipe_data[NS].cmd;
  assign pipe_ready[NS] = res_o.ready;
  assign res_o.valid    = pipe_valid[NS];
  assign res_o.bcd      = pipe_data[NS].bcd[b2bcd_pkg::OutW-1:0]
                          & b2bcd_pkg::digit_mask(out_cmd);

  // Checks
  a_ready_follows_sink: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.ready |-> req_i.ready)
    else $error("request stalled while result side ready");

  a_dig4_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && out_cmd == b2bcd_pkg::CmdDig4) |-> (res_o.bcd[31:16] == 16'h0))
    else $error("4-digit result has nonzero upper digits");

  a_dig6_upper_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && out_cmd == b2bcd_pkg::CmdDig6) |-> (res_o.bcd[31:24] == 8'h0))
    else $error("6-digit result has nonzero upper digits");

  a_digits_decimal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> b2bcd_pkg::bcd_digits_ok(res_o.bcd))
    else $error("result nibble above nine");

endmodule
